// ===== hdl/bsp_pkg.sv =====
// Shared types and constants for the bit stream packer.
// Holds the command codes and the work descriptor that the front end hands
// to the back end. Depends on nothing.
package bsp_pkg;

    // Default sizes of the packer.
    localparam int WORD_BITS_DEF = 64;
    localparam int ADDR_BITS_DEF = 24;

    // Fixed field widths of the item and result beats.
    localparam int DATA_BITS     = 64;
    localparam int CNT_BITS      = 13;
    localparam int ADDR_OUT_BITS = 24;
    localparam int OFFSET_BITS   = 30;
    localparam int PAD_BITS      = 6;
    localparam int FILL_BITS     = 6;
    localparam int WCNT_BITS     = 7;

    // A pad never emits more than this many words.
    localparam int MAX_WORDS     = 64;

    // Entries in the queue between front and back end.
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        CMD_WRITE_BITS = 3'd0,
        CMD_WRITE_BIT  = 3'd1,
        CMD_PAD        = 3'd2,
        CMD_FLUSH      = 3'd3,
        CMD_REWIND     = 3'd4
    } t_cmd;

    // One command's worth of output work for the back end.
    typedef struct packed {
        logic                   rewind;
        logic [WCNT_BITS-1:0]   word_count;
        logic [DATA_BITS-1:0]   first_data;
        logic [DATA_BITS-1:0]   remaining;
        logic [PAD_BITS-1:0]    padded;
        logic [FILL_BITS-1:0]   fill_count;
    } t_desc;

endpackage

// ===== hdl/bit_stream_packer_core.sv =====
// Bit stream packer, top level: front end, descriptor queue, back end.
// Depends on bsp_pkg, bsp_front, bsp_queue and bsp_back.
//
// Usage:
//   Commands enter through a queue-like port: a beat is taken at a clock
//   edge with push high and full low. Results leave through a queue-like
//   port: the oldest result sits on the o_ ports while empty is low and is
//   taken at an edge with pop high and empty low.
//   Every command gives one result, or one result per completed word; the
//   final result of a command has o_last set.
// Flow:
//   The front end takes one command at a time: in S_IDLE it latches the
//   beat and starts the pad division, in S_PUSH it plans the words and
//   hands a descriptor to the queue, waiting there while the queue is full.
//   A result passes from the latched beat through a queue entry to the back
//   end's output register. The back end gives one result per cycle while
//   pop is high, so a pad that completes N words gives N result beats.
// Reset and stalls:
//   Reset empties the queue and clears the partial word, its fill count and
//   the word index. While pop is low the back end holds its result, the
//   queue fills up to two descriptors and the front end then keeps full high.
module bit_stream_packer_core #(
    parameter int WORD_BITS = bsp_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = bsp_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          i_command,
    input  logic [bsp_pkg::DATA_BITS-1:0]       i_data_value,
    input  logic [bsp_pkg::CNT_BITS-1:0]        i_bit_count,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_word_valid,
    output logic [bsp_pkg::ADDR_OUT_BITS-1:0]   o_word_address,
    output logic [bsp_pkg::DATA_BITS-1:0]       o_word_data,
    output logic [bsp_pkg::DATA_BITS-1:0]       o_remaining_value,
    output logic [bsp_pkg::PAD_BITS-1:0]        o_padded_bits,
    output logic [bsp_pkg::OFFSET_BITS-1:0]     o_bit_offset,
    output logic                                o_last
);
    import bsp_pkg::*;

    t_desc  front_desc;
    logic   front_push;
    logic   queue_full;
    t_desc  queue_desc;
    logic   queue_empty;
    logic   queue_pop;

    // Command intake and planning.
    bsp_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_data_value (i_data_value),
        .i_bit_count  (i_bit_count),
        .o_desc       (front_desc),
        .o_desc_push  (front_push),
        .i_desc_full  (queue_full)
    );

    // Decoupling queue.
    bsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_desc  (front_desc),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_desc  (queue_desc),
        .o_empty (queue_empty)
    );

    // Result generation.
    bsp_back #(
        .WORD_BITS (WORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_desc            (queue_desc),
        .i_desc_empty      (queue_empty),
        .o_desc_pop        (queue_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_word_valid      (o_word_valid),
        .o_word_address    (o_word_address),
        .o_word_data       (o_word_data),
        .o_remaining_value (o_remaining_value),
        .o_padded_bits     (o_padded_bits),
        .o_bit_offset      (o_bit_offset),
        .o_last            (o_last)
    );

`ifndef ASSERT_OFF
    // Only word beats can be followed by more beats of the same command.
    a_nonlast_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> o_word_valid)
        else $error("non-final result without a word");

    // A result without a word carries a cleared address and data.
    a_empty_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_word_valid) |-> (o_word_address == '0 && o_word_data == '0))
        else $error("result without a word has address or data set");

    // The next beat of a command follows at once and is another word.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_word_valid))
        else $error("word burst broken");

    // All beats of one command report the same bit offset.
    a_burst_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (o_bit_offset == $past(o_bit_offset)))
        else $error("bit offset changed inside a command");
`endif

endmodule

// ===== hdl/bsp_front.sv =====
// Front end of the bit stream packer: accepts commands, holds the partial
// word and its fill count, and turns each command into a work descriptor.
// Depends on bsp_pkg.
module bsp_front #(
    parameter int WORD_BITS = bsp_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [2:0]                      i_command,
    input  logic [bsp_pkg::DATA_BITS-1:0]   i_data_value,
    input  logic [bsp_pkg::CNT_BITS-1:0]    i_bit_count,
    output bsp_pkg::t_desc                  o_desc,
    output logic                            o_desc_push,
    input  logic                            i_desc_full
);
    import bsp_pkg::*;

    // Division of the pad total by the word size uses a scaled reciprocal.
    localparam int DIV_SHIFT  = 20;
    localparam int RECIP      = (2**DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_BITS = DIV_SHIFT - 2;
    localparam int TOTAL_CAP  = (MAX_WORDS + 1) * WORD_BITS - 1;
    localparam int TOTAL_BITS = CNT_BITS;
    localparam int PROD_BITS  = TOTAL_BITS + RECIP_BITS;
    localparam logic [DATA_BITS-1:0] WORD_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - WORD_BITS);
    localparam logic [WCNT_BITS-1:0] WORD_BITS_W = WCNT_BITS'(WORD_BITS);

    typedef enum logic {
        S_IDLE,
        S_PUSH
    } t_state;

    t_state                 r_state;
    logic [2:0]             r_cmd;
    logic [DATA_BITS-1:0]   r_val;
    logic [WCNT_BITS-1:0]   r_n;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [PROD_BITS-1:0]   r_prod;
    logic [DATA_BITS-1:0]   r_buf;
    logic [FILL_BITS-1:0]   r_fill;

    logic [DATA_BITS-1:0]   n_buf;
    logic [FILL_BITS-1:0]   n_fill;

    // Accept side: saturate the write count and start the pad division.
    logic [TOTAL_BITS:0]    pad_sum;
    logic [TOTAL_BITS-1:0]  pad_total;
    logic [PROD_BITS-1:0]   pad_prod;
    logic [WCNT_BITS-1:0]   write_n;

    always_comb begin
        pad_sum   = (TOTAL_BITS+1)'(r_fill) + (TOTAL_BITS+1)'(i_bit_count);
        pad_total = (pad_sum > (TOTAL_BITS+1)'(TOTAL_CAP)) ? TOTAL_BITS'(TOTAL_CAP)
                                                           : pad_sum[TOTAL_BITS-1:0];
        pad_prod  = PROD_BITS'(pad_total) * PROD_BITS'(RECIP);
        write_n   = (i_bit_count > CNT_BITS'(WORD_BITS)) ? WORD_BITS_W
                                                         : i_bit_count[WCNT_BITS-1:0];
    end

    // Work side: merge the new bits and plan the words to emit.
    logic [DATA_BITS-1:0]   value_mask;
    logic [DATA_BITS-1:0]   wr_v;
    logic [DATA_BITS-1:0]   wr_merge;
    logic [DATA_BITS-1:0]   bit_merge;
    logic [WCNT_BITS-1:0]   wr_sum;
    logic [WCNT_BITS-1:0]   wr_used;
    logic [WCNT_BITS-1:0]   bit_sum;
    logic [WCNT_BITS-1:0]   pad_q0;
    logic [TOTAL_BITS-1:0]  pad_r0;
    logic [WCNT_BITS-1:0]   pad_q;
    logic [TOTAL_BITS-1:0]  pad_r;

    always_comb begin
        value_mask = (DATA_BITS'(1) << r_n) - DATA_BITS'(1);
        wr_v       = r_val & value_mask;
        wr_merge   = (r_buf | (wr_v << r_fill)) & WORD_MASK;
        wr_sum     = WCNT_BITS'(r_fill) + r_n;
        wr_used    = WORD_BITS_W - WCNT_BITS'(r_fill);
        bit_merge  = (r_buf | (DATA_BITS'(r_val[0]) << r_fill)) & WORD_MASK;
        bit_sum    = WCNT_BITS'(r_fill) + WCNT_BITS'(1);

        // Quotient from the reciprocal, with one correction step.
        pad_q0 = r_prod[DIV_SHIFT +: WCNT_BITS];
        pad_r0 = r_total - TOTAL_BITS'(pad_q0) * TOTAL_BITS'(WORD_BITS);
        if (pad_r0 >= TOTAL_BITS'(WORD_BITS)) begin
            pad_q = pad_q0 + WCNT_BITS'(1);
            pad_r = pad_r0 - TOTAL_BITS'(WORD_BITS);
        end else begin
            pad_q = pad_q0;
            pad_r = pad_r0;
        end

        n_buf             = r_buf;
        n_fill            = r_fill;
        o_desc.rewind     = 1'b0;
        o_desc.word_count = '0;
        o_desc.first_data = r_buf;
        o_desc.remaining  = '0;
        o_desc.padded     = '0;

        unique case (t_cmd'(r_cmd))
            CMD_WRITE_BITS: begin
                o_desc.remaining = r_val >> r_n;
                if (wr_sum >= WORD_BITS_W) begin
                    o_desc.word_count = WCNT_BITS'(1);
                    o_desc.first_data = wr_merge;
                    n_buf             = (wr_v >> wr_used) & WORD_MASK;
                    n_fill            = FILL_BITS'(wr_sum - WORD_BITS_W);
                end else begin
                    n_buf  = wr_merge;
                    n_fill = FILL_BITS'(wr_sum);
                end
            end
            CMD_WRITE_BIT: begin
                o_desc.remaining = DATA_BITS'(r_val[0]);
                if (bit_sum >= WORD_BITS_W) begin
                    o_desc.word_count = WCNT_BITS'(1);
                    o_desc.first_data = bit_merge;
                    n_buf             = '0;
                    n_fill            = '0;
                end else begin
                    n_buf  = bit_merge;
                    n_fill = FILL_BITS'(bit_sum);
                end
            end
            CMD_PAD: begin
                o_desc.word_count = pad_q;
                n_fill            = FILL_BITS'(pad_r);
                if (pad_q != '0) begin
                    n_buf = '0;
                end
            end
            CMD_FLUSH: begin
                if (r_fill != '0) begin
                    o_desc.word_count = WCNT_BITS'(1);
                    o_desc.padded     = PAD_BITS'(WORD_BITS_W - WCNT_BITS'(r_fill));
                    n_buf             = '0;
                    n_fill            = '0;
                end
            end
            CMD_REWIND: begin
                o_desc.rewind = 1'b1;
                n_buf         = '0;
                n_fill        = '0;
            end
            default: begin
            end
        endcase

        o_desc.fill_count = n_fill;
    end

    assign o_full      = (r_state != S_IDLE);
    assign o_desc_push = (r_state == S_PUSH) && !i_desc_full;

    // Command sequencing and the packing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_buf   <= '0;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_desc_full) begin
                        r_buf   <= n_buf;
                        r_fill  <= n_fill;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latched command beat.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_push) begin
            r_cmd   <= i_command;
            r_val   <= i_data_value;
            r_n     <= write_n;
            r_total <= pad_total;
            r_prod  <= pad_prod;
        end
    end

endmodule

// ===== hdl/bsp_queue.sv =====
// Short descriptor queue between the front and back ends of the packer.
// Register based, first in first out. Depends on bsp_pkg.
module bsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsp_pkg::t_desc  i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output bsp_pkg::t_desc  o_desc,
    output logic            o_empty
);
    import bsp_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    t_desc                  r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    r_wr;
    logic [PTR_BITS-1:0]    r_rd;
    logic [CNT_W-1:0]       r_count;

    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

// ===== hdl/bsp_back.sv =====
// Back end of the bit stream packer: expands each descriptor into result
// beats, one per cycle while results are taken, and keeps the output word index.
// Depends on bsp_pkg.
module bsp_back #(
    parameter int WORD_BITS = bsp_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = bsp_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsp_pkg::t_desc                      i_desc,
    input  logic                                i_desc_empty,
    output logic                                o_desc_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic                                o_word_valid,
    output logic [bsp_pkg::ADDR_OUT_BITS-1:0]   o_word_address,
    output logic [bsp_pkg::DATA_BITS-1:0]       o_word_data,
    output logic [bsp_pkg::DATA_BITS-1:0]       o_remaining_value,
    output logic [bsp_pkg::PAD_BITS-1:0]        o_padded_bits,
    output logic [bsp_pkg::OFFSET_BITS-1:0]     o_bit_offset,
    output logic                                o_last
);
    import bsp_pkg::*;

    logic                           r_valid;
    logic [WCNT_BITS-1:0]           r_left;
    logic [ADDR_BITS-1:0]           r_index;
    logic [ADDR_BITS-1:0]           r_addr;
    logic                           r_wv;
    logic [DATA_BITS-1:0]           r_data;
    logic [DATA_BITS-1:0]           r_rem;
    logic [PAD_BITS-1:0]            r_pad;
    logic [OFFSET_BITS-1:0]         r_off;
    logic                           r_last;

    logic                           advance;
    logic                           more;
    logic                           load;
    logic                           has_word;
    logic [ADDR_BITS-1:0]           base;
    logic [ADDR_BITS-1:0]           fin;
    logic [OFFSET_BITS-1:0]         off;
    logic [ADDR_BITS+ADDR_OUT_BITS-1:0] addr_ext;

    // Output register moves when empty or when the current beat is taken.
    always_comb begin
        advance  = !r_valid || i_pop;
        more     = r_valid && (r_left != '0);
        load     = advance && !more && !i_desc_empty;
        has_word = (i_desc.word_count != '0);
        base     = i_desc.rewind ? '0 : r_index;
        fin      = base + ADDR_BITS'(i_desc.word_count);
        off      = OFFSET_BITS'(OFFSET_BITS'(fin) * OFFSET_BITS'(WORD_BITS))
                   + OFFSET_BITS'(i_desc.fill_count);
        addr_ext = (ADDR_BITS+ADDR_OUT_BITS)'(r_addr);
    end

    assign o_desc_pop        = load;
    assign o_empty           = !r_valid;
    assign o_word_valid      = r_wv;
    assign o_word_address    = addr_ext[ADDR_OUT_BITS-1:0];
    assign o_word_data       = r_data;
    assign o_remaining_value = r_rem;
    assign o_padded_bits     = r_pad;
    assign o_bit_offset      = r_off;
    assign o_last            = r_last;

    // Beat sequencing and the word index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_index <= '0;
        end else if (advance) begin
            if (more) begin
                r_left <= r_left - WCNT_BITS'(1);
            end else if (!i_desc_empty) begin
                r_valid <= 1'b1;
                r_left  <= has_word ? i_desc.word_count - WCNT_BITS'(1) : '0;
                r_index <= fin;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (more) begin
                r_addr <= r_addr + ADDR_BITS'(1);
                r_data <= '0;
                r_last <= (r_left == WCNT_BITS'(1));
            end else if (!i_desc_empty) begin
                r_wv   <= has_word;
                r_addr <= has_word ? base : '0;
                r_data <= has_word ? i_desc.first_data : '0;
                r_rem  <= i_desc.remaining;
                r_pad  <= i_desc.padded;
                r_off  <= off;
                r_last <= (i_desc.word_count <= WCNT_BITS'(1));
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for bit_stream_packer_core; depends on it and on bsp_pkg.
// Drives commands through the push/full side, checks every result beat on the
// empty/pop side against a local packing model or a directed row's known result.
`timescale 1ns / 1ps

module tb_top;
    import bsp_pkg::*;

    localparam int WORD_BITS    = WORD_BITS_DEF;
    localparam int ADDR_BITS    = ADDR_BITS_DEF;
    localparam int NUM_DIR      = 23;
    localparam int NUM_RAND     = 107;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Command codes the block does not define; they must act as no-ops.
    localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam logic [DATA_BITS-1:0] ALL_ONES = '1;

    // One result beat as the block should present it.
    typedef struct packed {
        logic                     word_valid;
        logic [ADDR_OUT_BITS-1:0] word_address;
        logic [DATA_BITS-1:0]     word_data;
        logic [DATA_BITS-1:0]     remaining_value;
        logic [PAD_BITS-1:0]      padded_bits;
        logic [OFFSET_BITS-1:0]   bit_offset;
        logic                     last;
    } pack_result_t;

    // One row of the directed stimulus; known_result is used when has_known is set.
    typedef struct packed {
        logic [2:0]          command;
        logic [DATA_BITS-1:0] data_value;
        logic [CNT_BITS-1:0] bit_count;
        logic                has_known;
        pack_result_t        known_result;
    } stim_row_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    logic                         full;
    logic [2:0]                   i_command;
    logic [DATA_BITS-1:0]         i_data_value;
    logic [CNT_BITS-1:0]          i_bit_count;
    logic                         empty;
    logic                         pop;
    logic                         o_word_valid;
    logic [ADDR_OUT_BITS-1:0]     o_word_address;
    logic [DATA_BITS-1:0]         o_word_data;
    logic [DATA_BITS-1:0]         o_remaining_value;
    logic [PAD_BITS-1:0]          o_padded_bits;
    logic [OFFSET_BITS-1:0]       o_bit_offset;
    logic                         o_last;

    // Packing model state.
    logic [DATA_BITS-1:0]     model_buffer;
    int unsigned              model_fill;
    logic [ADDR_OUT_BITS-1:0] model_word_index;

    pack_result_t step_results[$];
    pack_result_t pending_results[$];
    pack_result_t beat_want;
    int           fail_count;
    int unsigned  cycle_count;

    // Directed rows: reset state, extremes, saturation, caps and unused codes.
    stim_row_t stim_table [NUM_DIR] = '{
        '{CMD_WRITE_BITS, ALL_ONES, 13'd0, 1'b1,
          '{1'b0, 24'd0, 64'd0, ALL_ONES, 6'd0, 30'd0, 1'b1}},
        '{CMD_UNUSED_5, 64'h0123_4567_89AB_CDEF, 13'd8191, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd0, 6'd0, 30'd0, 1'b1}},
        '{CMD_FLUSH, ALL_ONES, 13'd0, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd0, 6'd0, 30'd0, 1'b1}},
        '{CMD_WRITE_BIT, ALL_ONES, 13'd0, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd1, 6'd0, 30'd1, 1'b1}},
        '{CMD_WRITE_BITS, ALL_ONES, 13'd8191, 1'b1,
          '{1'b1, 24'd0, ALL_ONES, 64'd0, 6'd0, 30'd65, 1'b1}},
        '{CMD_REWIND, ALL_ONES, 13'd8191, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd0, 6'd0, 30'd0, 1'b1}},
        '{CMD_WRITE_BIT, 64'hFFFF_FFFF_FFFF_FFFE, 13'd0, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd0, 6'd0, 30'd1, 1'b1}},
        '{CMD_WRITE_BITS, 64'hA5A5_A5A5_A5A5_A5A5, 13'd64, 1'b0, '0},
        '{CMD_WRITE_BITS, 64'h5A5A_5A5A_5A5A_5A5A, 13'd63, 1'b0, '0},
        '{CMD_WRITE_BITS, 64'hFEDC_BA98_7654_3210, 13'd65, 1'b0, '0},
        '{CMD_WRITE_BITS, 64'h0000_0000_0000_0002, 13'd1, 1'b0, '0},
        '{CMD_PAD, ALL_ONES, 13'd0, 1'b0, '0},
        '{CMD_PAD, 64'd0, 13'd4096, 1'b0, '0},
        '{CMD_FLUSH, 64'd0, 13'd0, 1'b0, '0},
        '{CMD_PAD, 64'd0, 13'd8191, 1'b0, '0},
        '{CMD_FLUSH, ALL_ONES, 13'd8191, 1'b0, '0},
        '{CMD_UNUSED_6, ALL_ONES, 13'd5, 1'b0, '0},
        '{CMD_UNUSED_7, 64'd0, 13'd4096, 1'b0, '0},
        '{CMD_PAD, 64'd0, 13'd1, 1'b0, '0},
        '{CMD_WRITE_BITS, 64'd0, 13'd64, 1'b0, '0},
        '{CMD_REWIND, 64'd0, 13'd0, 1'b1,
          '{1'b0, 24'd0, 64'd0, 64'd0, 6'd0, 30'd0, 1'b1}},
        '{CMD_PAD, 64'd0, 13'd64, 1'b1,
          '{1'b1, 24'd0, 64'd0, 64'd0, 6'd0, 30'd64, 1'b1}},
        '{CMD_WRITE_BITS, 64'hDEAD_BEEF_CAFE_F00D, 13'd4096, 1'b0, '0}
    };

    bit_stream_packer_core #(
        .WORD_BITS (WORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_data_value      (i_data_value),
        .i_bit_count       (i_bit_count),
        .empty             (empty),
        .pop               (pop),
        .o_word_valid      (o_word_valid),
        .o_word_address    (o_word_address),
        .o_word_data       (o_word_data),
        .o_remaining_value (o_remaining_value),
        .o_padded_bits     (o_padded_bits),
        .o_bit_offset      (o_bit_offset),
        .o_last            (o_last)
    );

    // Record a completed word and advance the word index, which wraps at its width.
    function automatic void emit_word(input logic [DATA_BITS-1:0] word);
        pack_result_t r;
        r = '0;
        r.word_valid   = 1'b1;
        r.word_address = model_word_index;
        r.word_data    = word;
        step_results.push_back(r);
        model_word_index = model_word_index + 1'b1;
    endfunction

    // Append zero bits; the run is cut so that at most MAX_WORDS words come out.
    task automatic pad_zero_bits(input int unsigned pad_len);
        int unsigned          total;
        logic [DATA_BITS-1:0] first;
        total = model_fill + pad_len;
        if (total > (MAX_WORDS + 1) * WORD_BITS - 1)
            total = (MAX_WORDS + 1) * WORD_BITS - 1;
        first = model_buffer;
        while (total >= WORD_BITS) begin
            emit_word(first);
            first        = '0;
            model_buffer = '0;
            total       -= WORD_BITS;
        end
        model_fill = total;
    endtask

    // Work out the result beats of one command into step_results.
    task automatic pack_command(input logic [2:0] cmd, input logic [DATA_BITS-1:0] data,
                                input logic [CNT_BITS-1:0] count);
        int unsigned            n;
        int unsigned            used;
        int unsigned            padded;
        logic [DATA_BITS-1:0]   v;
        logic [DATA_BITS-1:0]   rem;
        logic [OFFSET_BITS-1:0] offset;
        pack_result_t           r;
        step_results.delete();
        rem    = '0;
        padded = 0;
        case (cmd)
            CMD_WRITE_BITS: begin
                n = (count > WORD_BITS) ? WORD_BITS : count;
                // A shift by the full width yields zero, so a count of 64 keeps all bits
                // and leaves nothing over.
                v   = data & ((64'd1 << n) - 64'd1);
                rem = data >> n;
                model_buffer = model_buffer | (v << model_fill);
                if (model_fill + n >= WORD_BITS) begin
                    used = WORD_BITS - model_fill;
                    emit_word(model_buffer);
                    model_buffer = v >> used;
                    model_fill   = model_fill + n - WORD_BITS;
                end else begin
                    model_fill = model_fill + n;
                end
            end
            CMD_WRITE_BIT: begin
                rem          = {63'd0, data[0]};
                model_buffer = model_buffer | (rem << model_fill);
                model_fill   = model_fill + 1;
                if (model_fill >= WORD_BITS) begin
                    emit_word(model_buffer);
                    model_buffer = '0;
                    model_fill   = 0;
                end
            end
            CMD_PAD: begin
                pad_zero_bits(count);
            end
            CMD_FLUSH: begin
                padded = (WORD_BITS - model_fill) % WORD_BITS;
                if (padded != 0)
                    pad_zero_bits(padded);
            end
            CMD_REWIND: begin
                model_buffer     = '0;
                model_fill       = 0;
                model_word_index = '0;
            end
            default: begin
            end
        endcase
        // A command that completes no word still gives one empty beat.
        if (step_results.size() == 0) begin
            r = '0;
            step_results.push_back(r);
        end
        offset = OFFSET_BITS'(model_word_index * WORD_BITS + model_fill);
        foreach (step_results[i]) begin
            step_results[i].remaining_value = rem;
            step_results[i].padded_bits     = PAD_BITS'(padded);
            step_results[i].bit_offset      = offset;
            step_results[i].last            = (i == step_results.size() - 1);
        end
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle limit against a hung handshake.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: pop follows a mode (always high, random, one in four, low) chosen anew at random after each run.
    initial begin
        int mode;
        int len;
        int phase;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 60);
            for (phase = 0; phase < len; phase++) begin
                @(negedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= (phase % 4 == 0);
                    default: pop <= 1'b0;
                endcase
            end
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result beat accepted with no expectation waiting");
                fail_count++;
            end else begin
                beat_want = pending_results.pop_front();
                if (o_word_valid !== beat_want.word_valid) begin
                    $error("word_valid: expected %0h, actual %0h",
                           beat_want.word_valid, o_word_valid);
                    fail_count++;
                end
                if (o_word_address !== beat_want.word_address) begin
                    $error("word_address: expected %0h, actual %0h",
                           beat_want.word_address, o_word_address);
                    fail_count++;
                end
                if (o_word_data !== beat_want.word_data) begin
                    $error("word_data: expected %0h, actual %0h",
                           beat_want.word_data, o_word_data);
                    fail_count++;
                end
                if (o_remaining_value !== beat_want.remaining_value) begin
                    $error("remaining_value: expected %0h, actual %0h",
                           beat_want.remaining_value, o_remaining_value);
                    fail_count++;
                end
                if (o_padded_bits !== beat_want.padded_bits) begin
                    $error("padded_bits: expected %0h, actual %0h",
                           beat_want.padded_bits, o_padded_bits);
                    fail_count++;
                end
                if (o_bit_offset !== beat_want.bit_offset) begin
                    $error("bit_offset: expected %0h, actual %0h",
                           beat_want.bit_offset, o_bit_offset);
                    fail_count++;
                end
                if (o_last !== beat_want.last) begin
                    $error("last: expected %0h, actual %0h", beat_want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Sender: reset, directed rows, then random commands in bursts.
    initial begin
        int                   idx;
        int                   sel;
        int                   burst_left;
        int                   gap;
        logic [2:0]           cmd;
        logic [DATA_BITS-1:0] data;
        logic [CNT_BITS-1:0]  count;
        fail_count       = 0;
        model_buffer     = '0;
        model_fill       = 0;
        model_word_index = '0;
        burst_left       = 0;
        i_rst_n          = 1'b0;
        push             = 1'b0;
        i_command        = CMD_WRITE_BITS;
        i_data_value     = '0;
        i_bit_count      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < NUM_DIR + NUM_RAND; idx++) begin
            // Hold off until the block has drained completely.
            if (idx == NUM_DIR || idx == NUM_DIR + NUM_RAND / 2) begin
                @(negedge i_clk);
                push <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    @(negedge i_clk);
                    push <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left--;

            if (idx < NUM_DIR) begin
                cmd   = stim_table[idx].command;
                data  = stim_table[idx].data_value;
                count = stim_table[idx].bit_count;
            end else begin
                // Mostly writes with small counts; pads are usually short.
                data  = {$urandom, $urandom};
                count = CNT_BITS'($urandom_range(0, 8191));
                sel   = $urandom_range(0, 99);
                if (sel < 45) begin
                    cmd = CMD_WRITE_BITS;
                    if ($urandom_range(0, 9) < 8)
                        count = CNT_BITS'($urandom_range(0, WORD_BITS));
                end else if (sel < 65) begin
                    cmd = CMD_WRITE_BIT;
                end else if (sel < 78) begin
                    cmd = CMD_PAD;
                    if ($urandom_range(0, 7) != 0)
                        count = CNT_BITS'($urandom_range(0, 150));
                end else if (sel < 90) begin
                    cmd = CMD_FLUSH;
                end else if (sel < 95) begin
                    cmd = CMD_REWIND;
                end else begin
                    cmd = 3'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
                end
            end

            @(negedge i_clk);
            push         <= 1'b1;
            i_command    <= cmd;
            i_data_value <= data;
            i_bit_count  <= count;
            do @(posedge i_clk); while (full);

            pack_command(cmd, data, count);
            if (idx < NUM_DIR && stim_table[idx].has_known)
                pending_results.push_back(stim_table[idx].known_result);
            else
                foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
